// ===== sv/ftt_pkg.sv =====
// Shared types and constants of the fractional tick timer.
package ftt_pkg;

    // Item kinds
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // Register map
    localparam logic [2:0] REG_INTR    = 3'd0;
    localparam logic [2:0] REG_INTR_EN = 3'd1;
    localparam logic [2:0] REG_NUM     = 3'd2;
    localparam logic [2:0] REG_DEN     = 3'd3;
    localparam logic [2:0] REG_TIME_LO = 3'd4;
    localparam logic [2:0] REG_TIME_HI = 3'd5;
    localparam logic [2:0] REG_ALARM   = 3'd6;

    localparam logic [31:0] ALARM_MASK = 32'hFFFF_FFE0;

    localparam int RATE_W = 16;
    localparam int CYC_W  = 32;
    localparam int PROD_W = CYC_W + RATE_W;     // dividend width, one step per bit
    localparam int CNT_W  = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

    // Controller to datapath
    typedef struct packed {
        logic accept;     // beat taken on the input channel
        logic div_step;   // one quotient bit
        logic add;        // accumulate quotient into time
        logic finish;     // alarm compare and result load
    } ftt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic long_tick;  // incoming beat is a tick with a live rate
    } ftt_sts_t;

endpackage

// ===== sv/ftt_ctrl.sv =====
// Sequencer of the fractional tick timer: item flow and divide step count.
module ftt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ftt_pkg::ftt_sts_t sts,
    output ftt_pkg::ftt_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_CMP  = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [ftt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      accept;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.add      = (state_reg == ST_ADD);
        cmd.finish   = (state_reg == ST_CMP);
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && sts.long_tick) begin
                    state_next = ST_DIV;
                    cnt_next   = ftt_pkg::LAST_STEP;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:  state_next = ST_CMP;
            ST_CMP:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if ((accept && !sts.long_tick) || cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register is empty for the whole of a long tick
    a_busy_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !m_valid_reg)
        else $error("result pending during tick");

    // Last divide step hands over to the accumulate
    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg == '0) |=> (state_reg == ST_ADD))
        else $error("divide did not end after last step");

    // A long tick starts with a full step count
    a_div_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && sts.long_tick) |=>
            (state_reg == ST_DIV && cnt_reg == ftt_pkg::LAST_STEP))
        else $error("divide entered with wrong count");

    // Finished tick always produces a beat
    a_finish_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid_reg)
        else $error("tick finished without result");

endmodule

// ===== sv/ftt_dp.sv =====
// Datapath of the fractional tick timer: register file, multiply, serial divide.
module ftt_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  ftt_pkg::ftt_cmd_t cmd,
    output ftt_pkg::ftt_sts_t sts,
    input  logic [1:0]        s_mode,
    input  logic [2:0]        s_reg_index,
    input  logic [31:0]       s_write_data,
    input  logic [31:0]       s_elapsed_cycles,
    output logic [31:0]       m_read_data,
    output logic              m_irq_line
);

    localparam int PW = ftt_pkg::PROD_W;
    localparam int RW = ftt_pkg::RATE_W;

    logic [63:0]   time_reg, time_next;
    logic [31:0]   alarm_reg, alarm_next;
    logic          pend_reg, pend_next;
    logic          en_reg, en_next;
    logic [RW-1:0] num_reg, num_next;
    logic [RW-1:0] den_reg, den_next;

    logic [PW-1:0] quo_reg;
    logic [RW-1:0] rem_reg;
    logic [31:0]   rd_reg, rd_next;
    logic          irq_reg;

    logic [PW-1:0] product;
    logic [RW:0]   rem_shift;
    logic          ge;
    logic [31:0]   den_data;
    logic          hit;
    logic          load_out;

    assign sts.long_tick = (s_mode == ftt_pkg::MODE_TICK) && (num_reg != '0) && (den_reg != '0);

    assign product   = PW'(s_elapsed_cycles) * PW'(num_reg);
    assign rem_shift = {rem_reg, quo_reg[PW-1]};
    assign ge        = rem_shift >= {1'b0, den_reg};
    assign den_data  = (s_write_data == '0) ? 32'd1 : s_write_data;
    // time >= alarm, alarm being only 32 bits wide
    assign hit       = (time_reg[63:32] != '0) || (time_reg[31:0] >= alarm_reg);
    assign load_out  = cmd.accept && !sts.long_tick;

    // Register reads and writes at the accepting edge, time accumulate and alarm pending set
    always_comb begin
        time_next  = time_reg;
        alarm_next = alarm_reg;
        pend_next  = pend_reg;
        en_next    = en_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rd_next    = '0;
        if (cmd.accept && s_mode == ftt_pkg::MODE_READ) begin
            case (s_reg_index)
                ftt_pkg::REG_INTR:    rd_next = {31'd0, pend_reg};
                ftt_pkg::REG_INTR_EN: rd_next = {31'd0, en_reg};
                ftt_pkg::REG_NUM:     rd_next = {{(32-RW){1'b0}}, num_reg};
                ftt_pkg::REG_DEN:     rd_next = {{(32-RW){1'b0}}, den_reg};
                ftt_pkg::REG_TIME_LO: rd_next = time_reg[31:0];
                ftt_pkg::REG_TIME_HI: rd_next = time_reg[63:32];
                ftt_pkg::REG_ALARM:   rd_next = alarm_reg;
                default:              rd_next = '0;
            endcase
        end
        if (cmd.accept && s_mode == ftt_pkg::MODE_WRITE) begin
            case (s_reg_index)
                ftt_pkg::REG_INTR:    if (s_write_data[0]) pend_next = 1'b0;
                ftt_pkg::REG_INTR_EN: en_next = s_write_data[0];
                ftt_pkg::REG_NUM:     num_next = s_write_data[RW-1:0];
                ftt_pkg::REG_DEN:     den_next = den_data[RW-1:0];
                ftt_pkg::REG_TIME_LO: time_next[31:0] = s_write_data & ftt_pkg::ALARM_MASK;
                ftt_pkg::REG_TIME_HI: time_next[63:32] = s_write_data & ftt_pkg::ALARM_MASK;
                ftt_pkg::REG_ALARM:   alarm_next = s_write_data & ftt_pkg::ALARM_MASK;
                default: ;
            endcase
        end
        if (cmd.add) begin
            time_next = time_reg + {{(64-PW){1'b0}}, quo_reg};
        end
        if (cmd.finish && hit) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg  <= '0;
            alarm_reg <= '0;
            pend_reg  <= 1'b0;
            en_reg    <= 1'b0;
            num_reg   <= '0;
            den_reg   <= '0;
        end else begin
            time_reg  <= time_next;
            alarm_reg <= alarm_next;
            pend_reg  <= pend_next;
            en_reg    <= en_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
        end
    end

    // Restoring divide, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            quo_reg <= product;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[PW-2:0], ge};
            rem_reg <= ge ? RW'(rem_shift - {1'b0, den_reg}) : rem_shift[RW-1:0];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (load_out || cmd.finish) begin
            rd_reg  <= rd_next;
            irq_reg <= pend_next & en_next;
        end
    end

    assign m_read_data = rd_reg;
    assign m_irq_line  = irq_reg;

endmodule

// ===== sv/fractional_tick_timer_with_alarm.sv =====
// Top level of the fractional tick timer with alarm interrupt.
//
//  channel | ports                                          | beat
//  --------+------------------------------------------------+--------------------------
//  in      | s_valid s_ready s_mode s_reg_index             | tick, register read or
//          | s_write_data s_elapsed_cycles                  | register write
//  out     | m_valid m_ready m_read_data m_irq_line         | one result per input beat
//
// Cycles: reads, writes and ticks with a zero rate complete on the accepting
// edge; the result is presented on the next cycle.
// A tick with a live rate is multiplied on acceptance, then passes through the
// bit-serial 48-by-16 restoring divider, then accumulates, then is compared
// against the alarm and loads the result.
// Reset: aresetn synchronous, active low; all timer registers clear to zero.
// Stalls: a new beat is taken while the previous result is still held as long
// as it leaves on the same edge; back-pressure on m_ready holds s_ready low.
module fractional_tick_timer_with_alarm (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [2:0]  s_reg_index,
    input  logic [31:0] s_write_data,
    input  logic [31:0] s_elapsed_cycles,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_irq_line
);

    ftt_pkg::ftt_cmd_t cmd;
    ftt_pkg::ftt_sts_t sts;

    // Sequencer: handshakes and divide step count
    ftt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Register file, rate arithmetic and result register
    ftt_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_mode           (s_mode),
        .s_reg_index      (s_reg_index),
        .s_write_data     (s_write_data),
        .s_elapsed_cycles (s_elapsed_cycles),
        .m_read_data      (m_read_data),
        .m_irq_line       (m_irq_line)
    );

endmodule
